[src/multi_lane_polynomial_string_hash_macros.svh]
// assertion macros used by the checker file
`ifndef MULTI_LANE_POLYNOMIAL_STRING_HASH_MACROS_SVH
`define MULTI_LANE_POLYNOMIAL_STRING_HASH_MACROS_SVH

// same-cycle implication, disabled during reset
`define MLPH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mlph check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define MLPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mlph check failed: next-cycle implication");

`endif

[src/mlph_pkg.sv]
// types and constants of the multi-lane polynomial string hash
`default_nettype none
package mlph_pkg;

	localparam int unsigned PRIME_REGS = 4;
	localparam int unsigned PRIME_W = 31;
	localparam int unsigned HASH_W = 32;
	localparam int unsigned MAG_W = 39;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned LANE_IDX_W = 2;
	localparam int unsigned RES_CNT_W = 3;

	localparam logic [HASH_W-1:0] HASH_SEED = 32'd1804289383;
	localparam logic [HASH_W-1:0] HASH_MODULUS = 32'd2147483629;
	// 2^31 is congruent to this value modulo the hash modulus
	localparam logic [HASH_W-1:0] MOD_FOLD = 32'd19;

	localparam logic [PRIME_W-1:0] PRIME_RESET [PRIME_REGS] =
		'{31'd31, 31'd37, 31'd41, 31'd43};

	typedef struct packed {
		logic [7:0] key_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [LANE_IDX_W-1:0] lane_index;
		logic signed [HASH_W-1:0] hash_value;
		logic                  run_end;
	} out_item_t;

	// per-byte control shared by all lanes
	typedef struct packed {
		logic load;     // input transfer this cycle
		logic first;    // transferred byte opens a key
		logic step;     // stage 1 moves into the hash registers
		logic first_s1; // byte in stage 1 opened its key
	} lane_ctl_t;

endpackage
`default_nettype wire

[src/mlph_lane.sv]
// one hash lane: power and product stage, then reduction and hash accumulate
`default_nettype none
module mlph_lane import mlph_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lane_ctl_t          ctl,
	input  wire logic [7:0]         key_byte,
	input  wire logic [PRIME_W-1:0] prime,
	output logic [HASH_W-1:0]       hash_sum
);

	logic [HASH_W-1:0] power_q;
	logic [HASH_W-1:0] power_eff;
	logic [HASH_W-1:0] power_next;
	logic [HASH_W-1:0] pmag;
	logic [7:0]        bmag;
	logic [MAG_W-1:0]  prod;
	logic              pneg;
	logic              bneg;
	logic [MAG_W-1:0]  mag_s1;
	logic              neg_s1;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] fold;
	logic [HASH_W-1:0] red;
	logic [HASH_W-1:0] term;
	logic [HASH_W-1:0] base;

	// power reloads from the prime at the start of a key
	assign power_eff = ctl.first ? {1'b0, prime} : power_q;
	assign power_next = power_eff * {1'b0, prime};

	// signed product as sign and magnitude
	assign pneg = power_eff[HASH_W-1];
	assign bneg = key_byte[7];
	assign pmag = pneg ? (~power_eff + 32'd1) : power_eff;
	assign bmag = bneg ? (~key_byte + 8'd1) : key_byte;
	assign prod = MAG_W'(pmag) * MAG_W'(bmag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q <= '0;
			mag_s1 <= '0;
			neg_s1 <= 1'b0;
		end else if (ctl.load) begin
			power_q <= power_next;
			mag_s1 <= prod;
			neg_s1 <= pneg ^ bneg;
		end
	end

	// fold the bits above 2^31, then one conditional subtract
	assign fold = {1'b0, mag_s1[30:0]} + 32'(mag_s1[MAG_W-1:31]) * MOD_FOLD;
	assign red = (fold >= HASH_MODULUS) ? (fold - HASH_MODULUS) : fold;
	assign term = neg_s1 ? (~red + 32'd1) : red;
	assign base = ctl.first_s1 ? HASH_SEED : hash_q;
	assign hash_sum = base + term;

	// hash accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
		end else if (ctl.step) begin
			hash_q <= hash_sum;
		end
	end

endmodule
`default_nettype wire

[src/mlph_outq.sv]
// result queue: holds the finished lane hashes and hands them out in lane order
`default_nettype none
module mlph_outq import mlph_pkg::*; #(
	parameter int unsigned OUT_LANES = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic [HASH_W-1:0] hashes [OUT_LANES],
	output logic                   free,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output out_item_t              out_data
);

	logic [HASH_W-1:0]     hq [OUT_LANES];
	logic [RES_CNT_W-1:0]  rem_q;
	logic [LANE_IDX_W-1:0] idx_q;
	logic                  take;

	assign out_valid = (rem_q != '0);
	assign take = out_valid && !out_stall;
	// room for a new set once the last queued result is transferred
	assign free = (rem_q == '0) || ((rem_q == RES_CNT_W'(1)) && !out_stall);

	// count and lane number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= RES_CNT_W'(OUT_LANES);
			idx_q <= '0;
		end else if (take) begin
			rem_q <= rem_q - RES_CNT_W'(1);
			idx_q <= idx_q + LANE_IDX_W'(1);
		end
	end

	// shift line of hashes, head at entry 0
	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < OUT_LANES; k++) begin
				hq[k] <= hashes[k];
			end
		end else if (take) begin
			for (int k = 0; k < OUT_LANES - 1; k++) begin
				hq[k] <= hq[k+1];
			end
		end
	end

	always_comb begin
		out_data.lane_index = idx_q;
		out_data.hash_value = hq[0];
		out_data.run_end = (rem_q == RES_CNT_W'(1));
	end

endmodule
`default_nettype wire

[src/multi_lane_polynomial_string_hash.sv]
// Multi-lane polynomial string hash, top level.
// Key bytes arrive on the in channel (in_valid / in_stall / in_data), one per
// transfer, with final_byte set on the last byte of a key. Each lane keeps a
// running power and a 32-bit hash; lane i uses prime register i mod 4.
// Results leave on the out channel, one per lane in lane order, run_end set
// on the last one; only the first four lanes are sent.
// Throughput: one byte per cycle while in_stall is low. A final byte fills the
// result queue with min(LANES,4) results; a following final byte waits in stage 1
// (in_stall high) until the queue has room, which sets the rate for very short keys.
// Results: a final byte loads the result queue when it steps out of stage 1,
// and its first result is then offered from the queue registers.
// Pipeline: stage 1 holds the power update and the 32x8 magnitude product;
// stage 2 reduces the product modulo 2147483629 and adds it to the hash.
// Reset restores the primes to 31, 37, 41, 43, empties the pipeline and the
// queue and starts a new key. A stalled result holds until taken; bytes keep
// flowing into the lanes while earlier results wait, but a final byte waits for room.
// The prime registers are written through cfg_we / cfg_index / cfg_data;
// indexes above three are ignored.
`default_nettype none
module multi_lane_polynomial_string_hash import mlph_pkg::*; #(
	parameter int unsigned LANES = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire in_item_t               in_data,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output out_item_t                   out_data,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [PRIME_W-1:0]     cfg_data
);

	localparam int unsigned OUT_LANES = (LANES < 4) ? LANES : 4;

	logic [PRIME_W-1:0] prime_q [PRIME_REGS];
	logic               key_open_q;
	logic               valid_s1;
	logic               last_s1;
	logic               first_s1;
	logic               accept;
	logic               step;
	logic               oq_free;
	lane_ctl_t          ctl;
	logic [HASH_W-1:0]  lane_sum [LANES];
	logic [HASH_W-1:0]  res_hash [OUT_LANES];

	// prime registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PRIME_REGS; k++) begin
				prime_q[k] <= PRIME_RESET[k];
			end
		end else if (cfg_we && (cfg_index < CFG_INDEX_W'(PRIME_REGS))) begin
			prime_q[cfg_index[1:0]] <= cfg_data;
		end
	end

	// stage 1 moves on unless a final byte finds the queue busy
	assign accept = in_valid && !in_stall;
	assign step = valid_s1 && (!last_s1 || oq_free);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_open_q <= 1'b0;
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !step);
			if (accept) begin
				key_open_q <= !in_data.final_byte;
				last_s1 <= in_data.final_byte;
				first_s1 <= !key_open_q;
			end
		end
	end

	always_comb begin
		ctl.load = accept;
		ctl.first = !key_open_q;
		ctl.step = step;
		ctl.first_s1 = first_s1;
	end

	// lanes
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		mlph_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.key_byte (in_data.key_byte),
			.prime    (prime_q[i % PRIME_REGS]),
			.hash_sum (lane_sum[i])
		);
	end

	for (genvar i = 0; i < OUT_LANES; i++) begin : g_res
		assign res_hash[i] = lane_sum[i];
	end

	// result queue
	mlph_outq #(
		.OUT_LANES (OUT_LANES)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && last_s1),
		.hashes    (res_hash),
		.free      (oq_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

[src/mlph_checker.sv]
// port-level checks of the hash block, bound to the top level
`default_nettype none
`include "multi_lane_polynomial_string_hash_macros.svh"
module mlph_checker import mlph_pkg::*; #(
	parameter int unsigned LANES = 4
) (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);

	localparam int unsigned OUT_LANES = (LANES < 4) ? LANES : 4;

	logic [LANE_IDX_W-1:0] next_idx;

	assign next_idx = out_data.lane_index + LANE_IDX_W'(1);

	// a stalled result holds
	`MLPH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data))

	// a stalled byte holds
	`MLPH_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall,
		in_valid && $stable(in_data))

	// the run ends on the last sent lane
	`MLPH_ASSERT_IMP(a_run_end_lane, clk, arst_n, out_valid && out_data.run_end,
		out_data.lane_index == LANE_IDX_W'(OUT_LANES - 1))

	// results of one key follow back to back in lane order
	`MLPH_ASSERT_NEXT(a_lane_order, clk, arst_n,
		out_valid && !out_stall && !out_data.run_end,
		out_valid && (out_data.lane_index == $past(next_idx)))

	// with no result pending the input never stalls
	`MLPH_ASSERT_IMP(a_no_stall_idle, clk, arst_n, !out_valid, !in_stall)

endmodule

bind multi_lane_polynomial_string_hash mlph_checker #(
	.LANES (LANES)
) u_mlph_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench for the multi-lane polynomial string hash
`timescale 1ns / 100ps
module testbench;
	import mlph_pkg::*;

	localparam int unsigned LANE_COUNT = 4;
	localparam int unsigned SENT_LANES = (LANE_COUNT < 4) ? LANE_COUNT : 4;

	localparam logic [CFG_INDEX_W-1:0] REG_PRIME_LANE0 = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PRIME_LANE1 = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PRIME_LANE2 = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PRIME_LANE3 = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [PRIME_W-1:0] PRIME_MIN = 31'd2;
	localparam logic [PRIME_W-1:0] PRIME_MAX = 31'h7FFF_FFFF;

	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ROUNDS = 6;
	localparam int ROUND_BYTES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [PRIME_W-1:0] cfg_data = '0;

	// pending key bytes and lane results still to come
	in_item_t key_bytes [$];
	out_item_t lane_results_due [$];

	// predicted block state
	logic [PRIME_W-1:0] prime_shadow [PRIME_REGS];
	logic [HASH_W-1:0] acc_hash [LANE_COUNT];
	logic [HASH_W-1:0] acc_power [LANE_COUNT];
	bit key_busy;

	bit in_calm;
	bit out_calm;
	int in_wait;
	int out_wait;
	int fail_count;
	int cycle_count;

	multi_lane_polynomial_string_hash #(
		.LANES(LANE_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// fold one byte into every lane, queue the lane hashes on the last byte
	function automatic void absorb_byte(in_item_t item);
		logic [HASH_W-1:0] mult;
		longint product;
		out_item_t res;
		for (int i = 0; i < LANE_COUNT; i++) begin
			mult = {1'b0, prime_shadow[i % PRIME_REGS]};
			if (!key_busy) begin
				acc_hash[i] = HASH_SEED;
				acc_power[i] = mult;
			end
			// signed product, remainder keeps the sign of the product
			product = longint'($signed(acc_power[i])) * longint'($signed(item.key_byte));
			product = product % longint'(HASH_MODULUS);
			acc_hash[i] = acc_hash[i] + product[HASH_W-1:0];
			acc_power[i] = acc_power[i] * mult;
		end
		key_busy = 1'b1;
		if (item.final_byte) begin
			for (int k = 0; k < SENT_LANES; k++) begin
				res.lane_index = k[LANE_IDX_W-1:0];
				res.hash_value = acc_hash[k];
				res.run_end = (k == SENT_LANES - 1);
				lane_results_due.push_back(res);
			end
			key_busy = 1'b0;
		end
	endfunction

	function automatic int draw_wait(bit calm);
		return calm ? 0 : int'($urandom_range(0, 7));
	endfunction

	// mostly random bytes, with the sign and range edges favored
	function automatic logic [7:0] draw_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'h7F;
			2: return 8'h80;
			3: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [PRIME_W-1:0] draw_prime();
		case ($urandom_range(0, 5))
			0: return PRIME_MIN;
			1: return PRIME_MAX;
			default: return PRIME_W'($urandom_range(2, 32'h7FFF_FFFF));
		endcase
	endfunction

	function automatic void push_byte(logic [7:0] b, logic fin);
		in_item_t item;
		item.key_byte = b;
		item.final_byte = fin;
		key_bytes.push_back(item);
	endfunction

	task automatic report_mismatch(input string what);
		if (fail_count < 40)
			$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	// write one register while the block is idle
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [PRIME_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx < PRIME_REGS)
			prime_shadow[idx[1:0]] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// wait for every byte to transfer and every result to arrive, then let the pipe drain
	task automatic settle();
		do
			@(negedge clk);
		while (key_bytes.size() != 0 || in_valid || lane_results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// byte driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				absorb_byte(in_data);
			// a stalled byte holds until its transfer
			if (!(in_valid && in_stall)) begin
				if (in_wait > 0) begin
					in_wait--;
					in_valid <= 1'b0;
				end else if (key_bytes.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= key_bytes.pop_front();
					in_wait = draw_wait(in_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin
		out_item_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (lane_results_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result lane %0d hash %0d",
					out_data.lane_index, out_data.hash_value));
			end else begin
				due = lane_results_due.pop_front();
				if (out_data.lane_index !== due.lane_index)
					report_mismatch($sformatf("lane_index %0d, want %0d",
						out_data.lane_index, due.lane_index));
				if (out_data.hash_value !== due.hash_value)
					report_mismatch($sformatf("lane %0d hash_value %0d, want %0d",
						due.lane_index, out_data.hash_value, due.hash_value));
				if (out_data.run_end !== due.run_end)
					report_mismatch($sformatf("lane %0d run_end %0b, want %0b",
						due.lane_index, out_data.run_end, due.run_end));
			end
			out_wait = draw_wait(out_calm);
		end
		if (out_wait > 0) begin
			out_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// run time limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		bit open_key;
		int len;
		int filled;
		prime_shadow = PRIME_RESET;
		key_busy = 1'b0;
		open_key = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset primes, no idling: one-byte key, byte extremes, zero byte, zero-only key
		in_calm = 1'b1;
		out_calm = 1'b1;
		push_byte(8'h41, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h01, 1'b1);
		push_byte(8'h00, 1'b1);
		settle();

		// extreme primes, plus writes to unused indexes that must be ignored
		write_reg(REG_PRIME_LANE0, PRIME_MIN);
		write_reg(REG_PRIME_LANE1, PRIME_MAX);
		write_reg(REG_PRIME_LANE2, PRIME_MAX);
		write_reg(REG_PRIME_LANE3, draw_prime());
		write_reg(REG_SPARE_LO, draw_prime());
		write_reg(REG_SPARE_HI, draw_prime());
		in_calm = 1'b0;
		out_calm = 1'b0;
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b1);

		// prime change in the middle of a key
		push_byte(8'h12, 1'b0);
		push_byte(8'h34, 1'b0);
		push_byte(8'h00, 1'b0);
		settle();
		write_reg(REG_PRIME_LANE0, PRIME_MAX);
		write_reg(REG_PRIME_LANE3, PRIME_MIN);
		push_byte(8'h80, 1'b0);
		push_byte(8'hFF, 1'b1);
		settle();

		// random keys, fresh primes between rounds, some rounds end inside a key
		for (int r = 0; r < RANDOM_ROUNDS; r++) begin
			in_calm = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 3) == 0);
			filled = 0;
			while (filled < ROUND_BYTES) begin
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(11, 24);
				else
					len = $urandom_range(1, 10);
				for (int b = 1; b <= len; b++)
					push_byte(draw_byte(), b == len);
				filled += len;
			end
			open_key = ($urandom_range(0, 2) == 0);
			if (open_key) begin
				len = $urandom_range(1, 4);
				for (int b = 0; b < len; b++)
					push_byte(draw_byte(), 1'b0);
			end
			settle();
			repeat ($urandom_range(1, 5))
				write_reg(CFG_INDEX_W'($urandom_range(0, 7)), draw_prime());
		end
		if (open_key)
			push_byte(draw_byte(), 1'b1);
		settle();

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/mlph_pkg.sv
src/mlph_lane.sv
src/mlph_outq.sv
src/multi_lane_polynomial_string_hash.sv
src/mlph_checker.sv
tb/sv/testbench.sv
